// ===== src/assert_macros.svh =====
// assertion macros used by the date conversion datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/dtcd_pkg.sv =====
// types and constants for the day count to calendar date converter
// no dependencies
package dtcd_pkg;

    localparam logic [11:0] YEAR_BASE   = 12'd2000;
    localparam logic [8:0]  DAYS_COMMON = 9'd365;
    localparam logic [8:0]  DAYS_LEAP   = 9'd366;
    localparam logic [6:0]  MOD100_LAST = 7'd99;
    localparam logic [8:0]  MOD400_LAST = 9'd399;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [3:0]  MONTH_FEB   = 4'd2;
    localparam logic [3:0]  MONTH_APR   = 4'd4;
    localparam logic [3:0]  MONTH_JUN   = 4'd6;
    localparam logic [3:0]  MONTH_SEP   = 4'd9;
    localparam logic [3:0]  MONTH_NOV   = 4'd11;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } t_dp_sts;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/dtcd_dp.sv =====
// datapath: remaining days, year and month counters, output register
// depends on dtcd_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtcd_dp import dtcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_day_count,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic [23:0] o_data
);

    logic [15:0] r_rest, n_rest;
    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [6:0]  r_mod100, n_mod100;
    logic [8:0]  r_mod400, n_mod400;
    logic [23:0] r_data, n_data;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    assign leap = ((r_year[1:0] == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
    assign mon_len  = month_length(r_month, leap);

    assign o_sts.year_done  = r_rest < {7'd0, year_len};
    assign o_sts.month_done = (r_month == MONTH_LAST) || (r_rest < {11'd0, mon_len});

    always_comb begin
        n_rest   = r_rest;
        n_year   = r_year;
        n_month  = r_month;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_data   = r_data;
        if (i_cmd.load) begin
            n_rest   = i_day_count;
            n_year   = YEAR_BASE;
            n_month  = MONTH_FIRST;
            n_mod100 = 7'd0;
            n_mod400 = 9'd0;
        end
        if (i_cmd.year_step) begin
            n_rest   = r_rest - {7'd0, year_len};
            n_year   = r_year + 12'd1;
            n_mod100 = (r_mod100 == MOD100_LAST) ? 7'd0 : r_mod100 + 7'd1;
            n_mod400 = (r_mod400 == MOD400_LAST) ? 9'd0 : r_mod400 + 9'd1;
        end
        if (i_cmd.month_step) begin
            n_rest  = r_rest - {11'd0, mon_len};
            n_month = r_month + 4'd1;
        end
        if (i_cmd.out_load) begin
            n_data = {3'd0, r_rest[4:0] + 5'd1, r_month, r_year};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest   <= n_rest;
        r_year   <= n_year;
        r_month  <= n_month;
        r_mod100 <= n_mod100;
        r_mod400 <= n_mod400;
        r_data   <= n_data;
    end

    assign o_data = r_data;

    `ASSERT_NEXT(a_year_inc, i_clk, i_rst_n, i_cmd.year_step, r_year == $past(r_year) + 12'd1)
    `ASSERT_SAME(a_month_bound, i_clk, i_rst_n, i_cmd.month_step, r_month < MONTH_LAST)
    `ASSERT_SAME(a_day_bound, i_clk, i_rst_n, i_cmd.out_load, r_rest < 16'd31)

endmodule

// ===== src/dtcd_ctrl.sv =====
// controller: sequences year and month subtraction, runs both handshakes
// depends on dtcd_pkg
module dtcd_ctrl import dtcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_YEARS  = 4'b0010,
        ST_MONTHS = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_tready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_YEARS;
                end
            end
            ST_YEARS: begin
                if (i_sts.year_done) begin
                    n_state = ST_MONTHS;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            ST_MONTHS: begin
                if (i_sts.month_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// ===== src/days_to_calendar_date_core.sv =====
// day count since 2000-01-01 to gregorian year, month and day
// the loaded day count has whole years, then whole months subtracted before the result is registered
// the next item is taken only after the previous result has entered the output register
// a finished result waits in the output register while the next item is taken
// synchronous active-low reset clears the controller and output valid
module days_to_calendar_date_core import dtcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // day_count[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // year_value[11:0], month_value[15:12], day_value[20:16]
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    dtcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_day_count (s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_data      (m_tdata)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for days_to_calendar_date_core: day counts in, checked calendar dates out
// predicts each date with its own calendar arithmetic; depends on dtcd_pkg and the core
module testbench import dtcd_pkg::*; ();

    localparam int RANDOM_ITEMS = 1075;
    localparam int PAUSE_EVERY  = 300;
    localparam int IDLE_LIMIT   = 20000;
    localparam int END_WAIT     = 250;
    localparam int HOLD_CYCLES  = 1200;
    localparam int PRINT_LIMIT  = 40;

    typedef enum logic {ENTRY_ITEM, ENTRY_DRAIN} t_entry_kind;

    typedef struct packed {
        t_entry_kind kind;
        logic [15:0] count;
    } t_send_entry;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_cal_date;

    typedef struct packed {
        logic [15:0] count;
        t_cal_date   date;
    } t_pending_date;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // day_count[15:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // year_value[11:0], month_value[15:12], day_value[20:16]

    t_send_entry   day_counts_to_send[$];
    t_pending_date expected_dates[$];
    t_send_entry   next_entry;
    t_pending_date oldest_date;

    bit in_fire      = 1'b0;
    int error_count  = 0;
    int results_seen = 0;
    int directed_items = 0;
    int leap_days_seen = 0;
    int latest_year  = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int drains_done  = 0;
    int hold_left    = 0;
    int next_hold_at = 200;
    int holds_done   = 0;
    int phase_left   = 0;
    int ready_pct    = 100;
    int idle_cycles  = 0;

    days_to_calendar_date_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_leap_year(input int year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    function automatic int days_in_month(input int month, input bit leap);
        int len;
        case (month)
            MONTH_FEB: len = leap ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    function automatic int first_day_of(input int year, input int month);
        int total;
        total = 0;
        for (int y = int'(YEAR_BASE); y < year; y++) begin
            total += is_leap_year(y) ? int'(DAYS_LEAP) : int'(DAYS_COMMON);
        end
        for (int m = int'(MONTH_FIRST); m < month; m++) begin
            total += days_in_month(m, is_leap_year(year));
        end
        return total;
    endfunction

    function automatic t_cal_date calendar_date_of(input logic [15:0] count);
        int rest;
        int year;
        int month;
        int len;
        t_cal_date date;
        rest  = int'(count);
        year  = int'(YEAR_BASE);
        month = int'(MONTH_FIRST);
        len   = is_leap_year(year) ? int'(DAYS_LEAP) : int'(DAYS_COMMON);
        while (rest >= len) begin
            rest -= len;
            year++;
            len = is_leap_year(year) ? int'(DAYS_LEAP) : int'(DAYS_COMMON);
        end
        while (month < int'(MONTH_LAST) && rest >= days_in_month(month, is_leap_year(year)))
        begin
            rest -= days_in_month(month, is_leap_year(year));
            month++;
        end
        date.year  = year[11:0];
        date.month = month[3:0];
        date.day   = 5'(rest + 1);
        return date;
    endfunction

    task automatic report_mismatch(input string what, input int count, input int got,
                                   input int want);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t mismatch: %s, day count %0d, got %0d, want %0d",
                     $time, what, count, got, want);
        end
        error_count++;
    endtask

    task automatic queue_count(input int count);
        t_send_entry entry;
        entry.kind  = ENTRY_ITEM;
        entry.count = count[15:0];
        day_counts_to_send.push_back(entry);
    endtask

    task automatic queue_drain();
        t_send_entry entry;
        entry.kind  = ENTRY_DRAIN;
        entry.count = '0;
        day_counts_to_send.push_back(entry);
    endtask

    // sender: bursts and gaps, drain markers wait for all dates to come back
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (day_counts_to_send.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (day_counts_to_send[0].kind == ENTRY_DRAIN) begin
            s_tvalid <= 1'b0;
            if (expected_dates.size() == 0) begin
                day_counts_to_send.delete(0);
                drains_done++;
            end
        end else begin
            next_entry = day_counts_to_send.pop_front();
            s_tdata  <= next_entry.count;
            s_tvalid <= 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 30);
                gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 250);
            end
        end
    end

    // receiver: random readiness phases plus occasional long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (results_seen >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 550;
            holds_done++;
            m_tready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1: ready_pct = 100;
                    2: ready_pct = 75;
                    3: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
                phase_left = $urandom_range(20, 300);
            end
            phase_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_tvalid && s_tready;
        if (in_fire) begin
            oldest_date.count = s_tdata;
            oldest_date.date  = calendar_date_of(s_tdata);
            expected_dates.push_back(oldest_date);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata[15:12] == MONTH_FEB && m_tdata[20:16] == 5'd29) leap_days_seen++;
            if (int'(m_tdata[11:0]) > latest_year) latest_year = int'(m_tdata[11:0]);
            if (expected_dates.size() == 0) begin
                report_mismatch("date with no item pending", -1, int'(m_tdata), 0);
            end else begin
                oldest_date = expected_dates.pop_front();
                if (m_tdata[11:0] !== oldest_date.date.year)
                    report_mismatch("year", int'(oldest_date.count), int'(m_tdata[11:0]),
                                    int'(oldest_date.date.year));
                if (m_tdata[15:12] !== oldest_date.date.month)
                    report_mismatch("month", int'(oldest_date.count), int'(m_tdata[15:12]),
                                    int'(oldest_date.date.month));
                if (m_tdata[20:16] !== oldest_date.date.day)
                    report_mismatch("day", int'(oldest_date.count), int'(m_tdata[20:16]),
                                    int'(oldest_date.date.day));
                if (m_tdata[23:21] !== 3'd0)
                    report_mismatch("pad bits", int'(oldest_date.count),
                                    int'(m_tdata[23:21]), 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("[days_to_calendar_date_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        int year;
        int month;
        int value;

        queue_count(0);
        queue_count(59);
        queue_count(60);
        queue_count(365);
        queue_count(366);
        for (int m = 1; m < 12; m++) begin
            queue_count(first_day_of(2001, m + 1) - 1);
        end
        queue_count(first_day_of(2002, 1) - 1);
        queue_count(first_day_of(2100, 3) - 1);
        queue_count(first_day_of(2100, 3));
        queue_count(first_day_of(2104, 3) - 1);
        queue_count(first_day_of(2179, 1));
        queue_count(65535);
        queue_count(16'h5555);
        queue_count(16'hAAAA);
        directed_items = day_counts_to_send.size();
        queue_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PAUSE_EVERY == PAUSE_EVERY - 1) queue_drain();
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                value = $urandom_range(0, 65535);
            end else begin
                // around a year or month boundary
                year  = $urandom_range(2000, 2179);
                month = (pick < 8) ? int'(MONTH_FIRST) : int'($urandom_range(1, 12));
                value = first_day_of(year, month) + int'($urandom_range(0, 2)) - 1;
                if (value < 0 || value > 65535) value = $urandom_range(0, 65535);
            end
            queue_count(value);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (day_counts_to_send.size() != 0 || s_tvalid || expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        while (expected_dates.size() != 0) begin
            oldest_date = expected_dates.pop_front();
            report_mismatch("date never delivered", int'(oldest_date.count), -1,
                            int'(oldest_date.date.year));
        end

        $display("checked %0d dates (%0d directed), %0d on February 29, latest year %0d",
                 results_seen, directed_items, leap_days_seen, latest_year);
        $display("receiver held off %0d times, sender drained %0d times, %0d mismatches",
                 holds_done, drains_done, error_count);
        if (error_count == 0) begin
            $display("[days_to_calendar_date_core] OK");
        end else begin
            $display("[days_to_calendar_date_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/dtcd_pkg.sv
src/dtcd_dp.sv
src/dtcd_ctrl.sv
src/days_to_calendar_date_core.sv
tb/sv/testbench.sv
